### src/triangle_critical_time_step_defines.svh
// Assertion macros used by the checker file of the triangle time step block.
`ifndef TRIANGLE_CRITICAL_TIME_STEP_DEFINES_SVH
`define TRIANGLE_CRITICAL_TIME_STEP_DEFINES_SVH

// Property checked at every rising clock edge, reset included.
`define TCTS_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is low.
`define TCTS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### src/tctsp_pkg.sv
// Shared constants, types and register codes of the triangle time step block.
package tctsp_pkg;

   // Word format of all coordinates, velocities and registers
   localparam int WordW = 32;
   localparam int FracW = 16;
   localparam int NumVert = 3;

   // Derived datapath widths
   localparam int DiffW = WordW + 1;          // coordinate difference
   localparam int ProdW = 2 * DiffW;          // signed product of two differences
   localparam int CrossW = ProdW + 1;         // difference of two products
   localparam int MagW = ProdW - 1;           // magnitude of k, s and |e|^2
   localparam int HiW = MagW - WordW;         // upper part of a split magnitude
   localparam int SqW = 2 * MagW;             // square of a magnitude
   localparam int TsqW = 2 * WordW;           // square of the speed threshold
   localparam int DivSteps = WordW;           // quotient bits
   localparam int NumW = MagW + FracW;        // dividend width
   localparam int OvfW = MagW + WordW - FracW; // width of the quotient overflow test

   // Queue between front and back end
   localparam int QueueDepth = 8;
   localparam int QueuePtrW = $clog2(QueueDepth);
   localparam int FrontStages = 5;

   // Configuration register indexes
   localparam int CsrIdxW = 1;
   typedef enum logic [CsrIdxW-1:0] {
      CsrMaxStep        = 1'b0,
      CsrSpeedThreshold = 1'b1
   } csr_index_type;

   typedef logic signed [WordW-1:0] word_type;

   // One triangle as it enters the front end; index 0..2 is vertex a..c
   typedef struct packed {
      word_type [NumVert-1:0] px;
      word_type [NumVert-1:0] py;
      word_type [NumVert-1:0] vx;
      word_type [NumVert-1:0] vy;
   } triangle_type;

   // Per-vertex terms after classification
   typedef struct packed {
      logic [MagW-1:0] s_mag;
      logic [MagW-1:0] e2;
      logic            s_pos;
   } vert_type;

   // One queue entry
   typedef struct packed {
      logic                     degen;
      logic [MagW-1:0]          k_mag;
      vert_type [NumVert-1:0]   vert;
   } item_type;

   // Control carried along the back-end pipeline
   typedef struct packed {
      logic valid;
      logic degen;
   } ctl_type;

endpackage

### src/tctsp_front.sv
// Front end: registers a triangle, forms edges, cross products and classifies it.
module tctsp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  tctsp_pkg::triangle_type trgl_in,
   output logic                    push_valid,
   output tctsp_pkg::item_type     push_item
);

   // F0: accepted beat
   logic                    f0_valid_ff;
   tctsp_pkg::triangle_type f0_trgl_ff;

   // F1: edge and offset vectors
   logic f1_valid_ff, f1_valid_in;
   logic signed [tctsp_pkg::DiffW-1:0] f1_ex_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_ey_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_dx_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_dy_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_vx_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_vy_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_ex_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_ey_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_dx_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_dy_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_vx_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::DiffW-1:0] f1_vy_in [tctsp_pkg::NumVert];

   // F2: products
   logic f2_valid_ff;
   logic signed [tctsp_pkg::ProdW-1:0] f2_kp_ff, f2_kn_ff, f2_kp_in, f2_kn_in;
   logic signed [tctsp_pkg::ProdW-1:0] f2_sp_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_sn_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_exx_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_eyy_ff [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_sp_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_sn_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_exx_in [tctsp_pkg::NumVert];
   logic signed [tctsp_pkg::ProdW-1:0] f2_eyy_in [tctsp_pkg::NumVert];

   // F3: doubled area k, signed s and |e|^2
   logic f3_valid_ff;
   logic [tctsp_pkg::CrossW-1:0] f3_k_ff, f3_k_in;
   logic [tctsp_pkg::CrossW-1:0] f3_s_ff [tctsp_pkg::NumVert];
   logic [tctsp_pkg::CrossW-1:0] f3_s_in [tctsp_pkg::NumVert];
   logic [tctsp_pkg::MagW-1:0]   f3_e2_ff [tctsp_pkg::NumVert];
   logic [tctsp_pkg::MagW-1:0]   f3_e2_in [tctsp_pkg::NumVert];

   // F4: classified item toward the queue
   logic                f4_valid_ff;
   tctsp_pkg::item_type f4_item_ff, f4_item_in;

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= accept;
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   assign f1_valid_in = f0_valid_ff;

   // Edge e = r - q and offset d = p - q, with q, r the far vertices of p
   always_comb begin
      for (int i = 0; i < tctsp_pkg::NumVert; i++) begin
         f1_ex_in[i] = $signed({f0_trgl_ff.px[(i+2)%tctsp_pkg::NumVert][tctsp_pkg::WordW-1],
                                f0_trgl_ff.px[(i+2)%tctsp_pkg::NumVert]})
                     - $signed({f0_trgl_ff.px[(i+1)%tctsp_pkg::NumVert][tctsp_pkg::WordW-1],
                                f0_trgl_ff.px[(i+1)%tctsp_pkg::NumVert]});
         f1_ey_in[i] = $signed({f0_trgl_ff.py[(i+2)%tctsp_pkg::NumVert][tctsp_pkg::WordW-1],
                                f0_trgl_ff.py[(i+2)%tctsp_pkg::NumVert]})
                     - $signed({f0_trgl_ff.py[(i+1)%tctsp_pkg::NumVert][tctsp_pkg::WordW-1],
                                f0_trgl_ff.py[(i+1)%tctsp_pkg::NumVert]});
         f1_dx_in[i] = $signed({f0_trgl_ff.px[i][tctsp_pkg::WordW-1], f0_trgl_ff.px[i]})
                     - $signed({f0_trgl_ff.px[(i+1)%tctsp_pkg::NumVert][tctsp_pkg::WordW-1],
                                f0_trgl_ff.px[(i+1)%tctsp_pkg::NumVert]});
         f1_dy_in[i] = $signed({f0_trgl_ff.py[i][tctsp_pkg::WordW-1], f0_trgl_ff.py[i]})
                     - $signed({f0_trgl_ff.py[(i+1)%tctsp_pkg::NumVert][tctsp_pkg::WordW-1],
                                f0_trgl_ff.py[(i+1)%tctsp_pkg::NumVert]});
         f1_vx_in[i] = $signed({f0_trgl_ff.vx[i][tctsp_pkg::WordW-1], f0_trgl_ff.vx[i]});
         f1_vy_in[i] = $signed({f0_trgl_ff.vy[i][tctsp_pkg::WordW-1], f0_trgl_ff.vy[i]});
      end
   end

   // One product per multiplier; k is the same for all three vertices
   always_comb begin
      f2_kp_in = f1_ex_ff[0] * f1_dy_ff[0];
      f2_kn_in = f1_ey_ff[0] * f1_dx_ff[0];
      for (int i = 0; i < tctsp_pkg::NumVert; i++) begin
         f2_sp_in[i]  = f1_vx_ff[i] * f1_ey_ff[i];
         f2_sn_in[i]  = f1_vy_ff[i] * f1_ex_ff[i];
         f2_exx_in[i] = f1_ex_ff[i] * f1_ex_ff[i];
         f2_eyy_in[i] = f1_ey_ff[i] * f1_ey_ff[i];
      end
   end

   // Differences of products, sign-extended by one bit, and the sum |e|^2
   always_comb begin
      f3_k_in = {f2_kp_ff[tctsp_pkg::ProdW-1], f2_kp_ff}
              - {f2_kn_ff[tctsp_pkg::ProdW-1], f2_kn_ff};
      for (int i = 0; i < tctsp_pkg::NumVert; i++) begin
         f3_s_in[i]  = {f2_sp_ff[i][tctsp_pkg::ProdW-1], f2_sp_ff[i]}
                     - {f2_sn_ff[i][tctsp_pkg::ProdW-1], f2_sn_ff[i]};
         f3_e2_in[i] = f2_exx_ff[i][tctsp_pkg::MagW-1:0] + f2_eyy_ff[i][tctsp_pkg::MagW-1:0];
      end
   end

   // Classify: fold the sign of k into s, flag zero area
   always_comb begin
      logic                         k_neg;
      logic [tctsp_pkg::CrossW-1:0] k_abs;
      logic [tctsp_pkg::CrossW-1:0] s_flip;
      k_neg = f3_k_ff[tctsp_pkg::CrossW-1];
      k_abs = k_neg ? ({tctsp_pkg::CrossW{1'b0}} - f3_k_ff) : f3_k_ff;
      f4_item_in.degen = (f3_k_ff == {tctsp_pkg::CrossW{1'b0}});
      f4_item_in.k_mag = k_abs[tctsp_pkg::MagW-1:0];
      for (int i = 0; i < tctsp_pkg::NumVert; i++) begin
         s_flip = k_neg ? ({tctsp_pkg::CrossW{1'b0}} - f3_s_ff[i]) : f3_s_ff[i];
         f4_item_in.vert[i].s_mag = s_flip[tctsp_pkg::MagW-1:0];
         f4_item_in.vert[i].s_pos = ~s_flip[tctsp_pkg::CrossW-1]
                                  & (s_flip != {tctsp_pkg::CrossW{1'b0}});
         f4_item_in.vert[i].e2    = f3_e2_ff[i];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      f0_trgl_ff <= trgl_in;
      f1_ex_ff   <= f1_ex_in;
      f1_ey_ff   <= f1_ey_in;
      f1_dx_ff   <= f1_dx_in;
      f1_dy_ff   <= f1_dy_in;
      f1_vx_ff   <= f1_vx_in;
      f1_vy_ff   <= f1_vy_in;
      f2_kp_ff   <= f2_kp_in;
      f2_kn_ff   <= f2_kn_in;
      f2_sp_ff   <= f2_sp_in;
      f2_sn_ff   <= f2_sn_in;
      f2_exx_ff  <= f2_exx_in;
      f2_eyy_ff  <= f2_eyy_in;
      f3_k_ff    <= f3_k_in;
      f3_s_ff    <= f3_s_in;
      f3_e2_ff   <= f3_e2_in;
      f4_item_ff <= f4_item_in;
   end

   assign push_valid = f4_valid_ff;
   assign push_item  = f4_item_ff;

endmodule

### src/tctsp_queue.sv
// Short queue between front and back end; the back end drains one beat per cycle while it is not empty.
module tctsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_valid,
   input  tctsp_pkg::item_type             push_item,
   output logic                            pop_valid,
   output tctsp_pkg::item_type             pop_item,
   output logic [tctsp_pkg::QueuePtrW:0]   level
);

   tctsp_pkg::item_type mem_ff [tctsp_pkg::QueueDepth];

   logic [tctsp_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tctsp_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tctsp_pkg::QueuePtrW:0]   count_ff, count_in;
   logic                            pop;

   assign pop = (count_ff != '0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (tctsp_pkg::QueuePtrW+1)'(push_valid)
                           - (tctsp_pkg::QueuePtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid = pop;
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

### src/tctsp_vertex.sv
// Back-end lane for one vertex: speed test, pipelined division, saturation.
module tctsp_vertex (
   input  logic                          clock,
   input  logic                          reset,
   input  tctsp_pkg::ctl_type            ctl_in,
   input  logic [tctsp_pkg::MagW-1:0]    k_mag,
   input  tctsp_pkg::vert_type           vert,
   input  logic [tctsp_pkg::TsqW-1:0]    tsq,
   input  logic [tctsp_pkg::WordW-1:0]   max_step,
   output tctsp_pkg::ctl_type            ctl_out,
   output logic [tctsp_pkg::WordW-1:0]   vert_time
);

   localparam int LoW = tctsp_pkg::WordW;
   localparam int HiW = tctsp_pkg::HiW;
   localparam int XsW = LoW + HiW + 1;

   // P1: partial products of s^2 and tsq * e2
   tctsp_pkg::ctl_type            p1_ctl_ff, p1_ctl_in;
   logic [tctsp_pkg::MagW-1:0]    p1_k_ff, p1_s_ff;
   logic                          p1_lim_ff, p1_lim_in;
   logic [2*LoW-1:0]              p1_sll_ff, p1_sll_in;
   logic [LoW+HiW-1:0]            p1_slh_ff, p1_slh_in;
   logic [2*HiW-1:0]              p1_shh_ff, p1_shh_in;
   logic [2*LoW-1:0]              p1_tll_ff, p1_tll_in;
   logic [LoW+HiW-1:0]            p1_tlh_ff, p1_tlh_in;
   logic [2*LoW-1:0]              p1_thl_ff, p1_thl_in;
   logic [LoW+HiW-1:0]            p1_thh_ff, p1_thh_in;

   // P2: s^2 complete, tsq * e2 in two parts
   tctsp_pkg::ctl_type            p2_ctl_ff;
   logic [tctsp_pkg::MagW-1:0]    p2_k_ff, p2_s_ff;
   logic                          p2_lim_ff;
   logic [tctsp_pkg::SqW-1:0]     p2_sq_ff, p2_sq_in, p2_tbase_ff, p2_tbase_in;
   logic [XsW-1:0]                p2_tcross_ff, p2_tcross_in;

   // P3: both sides of the speed test
   tctsp_pkg::ctl_type            p3_ctl_ff;
   logic [tctsp_pkg::MagW-1:0]    p3_k_ff, p3_s_ff;
   logic                          p3_lim_ff;
   logic [tctsp_pkg::SqW-1:0]     p3_sq_ff, p3_te_ff, p3_te_in;

   // Division stages; each stage after stage 0 adds one quotient bit
   tctsp_pkg::ctl_type            d_ctl_ff [tctsp_pkg::DivSteps+1];
   tctsp_pkg::ctl_type            d_ctl_in [tctsp_pkg::DivSteps+1];
   logic                          d_lim_ff [tctsp_pkg::DivSteps+1];
   logic                          d_lim_in [tctsp_pkg::DivSteps+1];
   logic                          d_ovf_ff [tctsp_pkg::DivSteps+1];
   logic                          d_ovf_in [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::MagW-1:0]    d_s_ff [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::MagW-1:0]    d_s_in [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::MagW-1:0]    d_rem_ff [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::MagW-1:0]    d_rem_in [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::WordW-1:0]   d_low_ff [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::WordW-1:0]   d_low_in [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::WordW-1:0]   d_quo_ff [tctsp_pkg::DivSteps+1];
   logic [tctsp_pkg::WordW-1:0]   d_quo_in [tctsp_pkg::DivSteps+1];

   // Output
   tctsp_pkg::ctl_type            out_ctl_ff;
   logic [tctsp_pkg::WordW-1:0]   out_time_ff, out_time_in;

   // P1 products, each 33 by 33 bits at most
   always_comb begin
      p1_ctl_in = ctl_in;
      p1_lim_in = vert.s_pos & ~ctl_in.degen;
      p1_sll_in = vert.s_mag[LoW-1:0] * vert.s_mag[LoW-1:0];
      p1_slh_in = vert.s_mag[LoW-1:0] * vert.s_mag[tctsp_pkg::MagW-1:LoW];
      p1_shh_in = vert.s_mag[tctsp_pkg::MagW-1:LoW] * vert.s_mag[tctsp_pkg::MagW-1:LoW];
      p1_tll_in = tsq[LoW-1:0] * vert.e2[LoW-1:0];
      p1_tlh_in = tsq[LoW-1:0] * vert.e2[tctsp_pkg::MagW-1:LoW];
      p1_thl_in = tsq[tctsp_pkg::TsqW-1:LoW] * vert.e2[LoW-1:0];
      p1_thh_in = tsq[tctsp_pkg::TsqW-1:LoW] * vert.e2[tctsp_pkg::MagW-1:LoW];
   end

   // P2 partial sums; the outer products sit side by side without an add
   always_comb begin
      p2_sq_in     = {p1_shh_ff, p1_sll_ff}
                   + (tctsp_pkg::SqW'(p1_slh_ff) << (LoW + 1));
      p2_tbase_in  = tctsp_pkg::SqW'({p1_thh_ff, p1_tll_ff});
      p2_tcross_in = XsW'(p1_tlh_ff) + XsW'(p1_thl_ff);
   end

   assign p3_te_in = p2_tbase_ff + (tctsp_pkg::SqW'(p2_tcross_ff) << LoW);

   // Divider: stage 0 does the speed test, overflow test and dividend split,
   // the following stages are restoring division steps
   always_comb begin
      logic [tctsp_pkg::NumW-1:0] num;
      logic [tctsp_pkg::MagW:0]   rem_sh;
      logic                       ge;
      num          = {p3_k_ff, {tctsp_pkg::FracW{1'b0}}};
      d_ctl_in[0]  = p3_ctl_ff;
      d_lim_in[0]  = p3_lim_ff & (p3_sq_ff > p3_te_ff);
      d_ovf_in[0]  = tctsp_pkg::OvfW'(p3_k_ff)
                     >= (tctsp_pkg::OvfW'(p3_s_ff) << (tctsp_pkg::WordW - tctsp_pkg::FracW));
      d_s_in[0]    = p3_s_ff;
      d_rem_in[0]  = tctsp_pkg::MagW'(num[tctsp_pkg::NumW-1:tctsp_pkg::WordW]);
      d_low_in[0]  = num[tctsp_pkg::WordW-1:0];
      d_quo_in[0]  = '0;
      for (int j = 0; j < tctsp_pkg::DivSteps; j++) begin
         rem_sh        = {d_rem_ff[j], d_low_ff[j][tctsp_pkg::WordW-1]};
         ge            = (rem_sh >= {1'b0, d_s_ff[j]});
         d_rem_in[j+1] = ge ? tctsp_pkg::MagW'(rem_sh - {1'b0, d_s_ff[j]})
                            : rem_sh[tctsp_pkg::MagW-1:0];
         d_low_in[j+1] = {d_low_ff[j][tctsp_pkg::WordW-2:0], 1'b0};
         d_quo_in[j+1] = {d_quo_ff[j][tctsp_pkg::WordW-2:0], ge};
         d_ctl_in[j+1] = d_ctl_ff[j];
         d_lim_in[j+1] = d_lim_ff[j];
         d_ovf_in[j+1] = d_ovf_ff[j];
         d_s_in[j+1]   = d_s_ff[j];
      end
   end

   // Saturate to the largest step
   assign out_time_in = (d_lim_ff[tctsp_pkg::DivSteps] && !d_ovf_ff[tctsp_pkg::DivSteps]
                         && (d_quo_ff[tctsp_pkg::DivSteps] <= max_step))
                      ? d_quo_ff[tctsp_pkg::DivSteps] : max_step;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff  <= '0;
         p2_ctl_ff  <= '0;
         p3_ctl_ff  <= '0;
         out_ctl_ff <= '0;
         for (int j = 0; j <= tctsp_pkg::DivSteps; j++) begin
            d_ctl_ff[j] <= '0;
         end
      end else begin
         p1_ctl_ff  <= p1_ctl_in;
         p2_ctl_ff  <= p1_ctl_ff;
         p3_ctl_ff  <= p2_ctl_ff;
         d_ctl_ff   <= d_ctl_in;
         out_ctl_ff <= d_ctl_ff[tctsp_pkg::DivSteps];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p1_k_ff      <= k_mag;
      p1_s_ff      <= vert.s_mag;
      p1_lim_ff    <= p1_lim_in;
      p1_sll_ff    <= p1_sll_in;
      p1_slh_ff    <= p1_slh_in;
      p1_shh_ff    <= p1_shh_in;
      p1_tll_ff    <= p1_tll_in;
      p1_tlh_ff    <= p1_tlh_in;
      p1_thl_ff    <= p1_thl_in;
      p1_thh_ff    <= p1_thh_in;
      p2_k_ff      <= p1_k_ff;
      p2_s_ff      <= p1_s_ff;
      p2_lim_ff    <= p1_lim_ff;
      p2_sq_ff     <= p2_sq_in;
      p2_tbase_ff  <= p2_tbase_in;
      p2_tcross_ff <= p2_tcross_in;
      p3_k_ff      <= p2_k_ff;
      p3_s_ff      <= p2_s_ff;
      p3_lim_ff    <= p2_lim_ff;
      p3_sq_ff     <= p2_sq_ff;
      p3_te_ff     <= p3_te_in;
      d_lim_ff     <= d_lim_in;
      d_ovf_ff     <= d_ovf_in;
      d_s_ff       <= d_s_in;
      d_rem_ff     <= d_rem_in;
      d_low_ff     <= d_low_in;
      d_quo_ff     <= d_quo_in;
      out_time_ff  <= out_time_in;
   end

   assign ctl_out   = out_ctl_ff;
   assign vert_time = out_time_ff;

endmodule

### src/triangle_critical_time_step.sv
// Top level of the triangle critical time step engine.
// Takes one triangle per clock: a start beat is taken whenever busy is low, and busy
// stays low under continuous traffic because the back end drains the queue every
// cycle. Each result appears on rsp_* with rsp_valid for exactly one cycle, in order;
// the receiver cannot stall it. A result passes the front pipeline (5 stages), the
// queue (1), the speed test (4 stages), the restoring divider (one stage per quotient
// bit, 32) and two output registers.
// Write csr_* only while no triangle is in flight.
module triangle_critical_time_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_x_a,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_y_a,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_x_b,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_y_b,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_x_c,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_y_c,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_vel_ax,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_vel_ay,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_vel_bx,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_vel_by,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_vel_cx,
   input  logic signed [tctsp_pkg::WordW-1:0]  req_vel_cy,
   output logic                                rsp_valid,
   output logic        [tctsp_pkg::WordW-1:0]  rsp_step_limit,
   output logic                                rsp_degenerate,
   input  logic                                csr_write_en,
   input  logic        [tctsp_pkg::CsrIdxW-1:0] csr_index,
   input  logic        [tctsp_pkg::WordW-1:0]  csr_wdata
);

   // Configuration registers and the squared threshold
   logic [tctsp_pkg::WordW-1:0] max_step_ff, max_step_in;
   logic [tctsp_pkg::WordW-1:0] thr_ff, thr_in;
   logic [tctsp_pkg::TsqW-1:0]  tsq_ff, tsq_in;

   tctsp_pkg::triangle_type      trgl;
   logic                         accept;
   logic                         push_valid, pop_valid;
   tctsp_pkg::item_type          push_item, pop_item;
   logic [tctsp_pkg::QueuePtrW:0] q_level;
   tctsp_pkg::ctl_type           lane_ctl_in;
   tctsp_pkg::ctl_type           lane_ctl [tctsp_pkg::NumVert];
   logic [tctsp_pkg::WordW-1:0]  lane_time [tctsp_pkg::NumVert];

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_degen_ff;
   logic [tctsp_pkg::WordW-1:0]  rsp_step_ff, rsp_step_in;

   // Register writes
   always_comb begin
      max_step_in = max_step_ff;
      thr_in      = thr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tctsp_pkg::CsrMaxStep:        max_step_in = csr_wdata;
            tctsp_pkg::CsrSpeedThreshold: thr_in      = csr_wdata;
            default:                      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= tctsp_pkg::WordW'(1) << tctsp_pkg::FracW;
         thr_ff      <= tctsp_pkg::WordW'(1);
      end else begin
         max_step_ff <= max_step_in;
         thr_ff      <= thr_in;
      end
   end

   assign tsq_in = thr_ff * thr_ff;

   always_ff @(posedge clock) begin
      tsq_ff <= tsq_in;
   end

   // Input beat
   assign trgl.px = {req_x_c, req_x_b, req_x_a};
   assign trgl.py = {req_y_c, req_y_b, req_y_a};
   assign trgl.vx = {req_vel_cx, req_vel_bx, req_vel_ax};
   assign trgl.vy = {req_vel_cy, req_vel_by, req_vel_ay};

   // Hold off once the queue could not absorb every beat still in the front end
   assign busy   = (q_level >= (tctsp_pkg::QueuePtrW+1)'(tctsp_pkg::QueueDepth
                                                         - tctsp_pkg::FrontStages));
   assign accept = start & ~busy;

   tctsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .trgl_in    (trgl),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   tctsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .level      (q_level)
   );

   assign lane_ctl_in.valid = pop_valid;
   assign lane_ctl_in.degen = pop_item.degen;

   // One back-end lane per vertex
   for (genvar v = 0; v < tctsp_pkg::NumVert; v++) begin : g_lane
      tctsp_vertex u_vertex (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (lane_ctl_in),
         .k_mag     (pop_item.k_mag),
         .vert      (pop_item.vert[v]),
         .tsq       (tsq_ff),
         .max_step  (max_step_ff),
         .ctl_out   (lane_ctl[v]),
         .vert_time (lane_time[v])
      );
   end

   // Minimum of the three vertex times, or the largest step for a degenerate triangle
   always_comb begin
      logic [tctsp_pkg::WordW-1:0] best;
      best = lane_time[0];
      if (lane_time[1] < best) begin
         best = lane_time[1];
      end
      if (lane_time[2] < best) begin
         best = lane_time[2];
      end
      rsp_step_in  = lane_ctl[0].degen ? max_step_ff : best;
      rsp_valid_in = lane_ctl[0].valid & lane_ctl[1].valid & lane_ctl[2].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_step_ff  <= rsp_step_in;
      rsp_degen_ff <= lane_ctl[0].degen;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_limit = rsp_step_ff;
   assign rsp_degenerate = rsp_valid_ff & rsp_degen_ff;

endmodule

### src/tctsp_checker.sv
// Port-level checker of the triangle time step engine and its bind.
`include "triangle_critical_time_step_defines.svh"

module tctsp_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_degenerate
);

   // Reset flushes every beat in flight
   `TCTS_ASSERT(a_reset_flush, clock, reset |=> !rsp_valid, "result beat right after reset")

   // Queue is empty after reset, so a start beat is taken at once
   `TCTS_ASSERT(a_reset_ready, clock, reset |=> !busy, "busy right after reset")

   // Degenerate flag only travels with a result beat
   `TCTS_ASSERT_RST(a_degen_qual, clock, reset, !rsp_valid |-> !rsp_degenerate, "stray degenerate flag")

endmodule

bind triangle_critical_time_step tctsp_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_degenerate (rsp_degenerate)
);

### dv/testbench.sv
// Self-checking testbench of the triangle critical time step block.
`timescale 1ns / 1ps

module testbench;

   typedef enum logic [1:0] {OpTriangle, OpCsrWrite, OpDrain} op_kind_type;

   typedef struct {
      op_kind_type                         kind;
      tctsp_pkg::word_type                 f [12];  // x_a y_a x_b y_b x_c y_c vax .. vcy
      tctsp_pkg::csr_index_type            idx;
      logic [tctsp_pkg::WordW-1:0]         wdata;
      logic                                dense;   // no idle gaps after this beat
   } pending_type;

   typedef struct {
      logic [tctsp_pkg::WordW-1:0] step_limit;
      logic                        degenerate;
   } step_type;

   logic clock, reset, start, busy;
   tctsp_pkg::word_type req_f [12];
   logic rsp_valid, rsp_degenerate;
   logic [tctsp_pkg::WordW-1:0] rsp_step_limit;
   logic csr_write_en;
   tctsp_pkg::csr_index_type csr_index;
   logic [tctsp_pkg::WordW-1:0] csr_wdata;

   pending_type pending_beats[$];
   step_type    expected_steps[$];
   logic [tctsp_pkg::WordW-1:0] max_step_shadow, threshold_shadow;
   int  gap_left, idle_cycles;
   bit  failed;

   triangle_critical_time_step dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_a(req_f[0]), .req_y_a(req_f[1]), .req_x_b(req_f[2]), .req_y_b(req_f[3]),
      .req_x_c(req_f[4]), .req_y_c(req_f[5]),
      .req_vel_ax(req_f[6]), .req_vel_ay(req_f[7]), .req_vel_bx(req_f[8]),
      .req_vel_by(req_f[9]), .req_vel_cx(req_f[10]), .req_vel_cy(req_f[11]),
      .rsp_valid(rsp_valid), .rsp_step_limit(rsp_step_limit),
      .rsp_degenerate(rsp_degenerate),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Time for vertex p against edge q->r, exact wide integer math
   function automatic logic [tctsp_pkg::WordW-1:0] vertex_time(
      tctsp_pkg::word_type px, tctsp_pkg::word_type py,
      tctsp_pkg::word_type qx, tctsp_pkg::word_type qy,
      tctsp_pkg::word_type rx, tctsp_pkg::word_type ry,
      tctsp_pkg::word_type vx, tctsp_pkg::word_type vy, inout logic degen);
      logic signed [127:0] ex, ey, dx, dy, k, s, wvx, wvy;
      logic [255:0] e2, s_sq, lim, quo, num;
      ex = rx; ex = ex - qx;
      ey = ry; ey = ey - qy;
      dx = px; dx = dx - qx;
      dy = py; dy = dy - qy;
      wvx = vx; wvy = vy;
      k = ex * dy - ey * dx;
      s = wvx * ey - wvy * ex;
      if (k == 0) begin
         degen = 1'b1;
         return max_step_shadow;
      end
      if (k < 0) begin
         k = -k;
         s = -s;
      end
      if (s <= 0) return max_step_shadow;
      e2 = 256'(ex * ex + ey * ey);
      s_sq = 256'(s);
      s_sq = s_sq * s_sq;
      lim = 256'(threshold_shadow);
      lim = lim * lim * e2;
      if (s_sq <= lim) return max_step_shadow;
      num = 256'(k) << tctsp_pkg::FracW;
      quo = num / 256'(s);
      if (quo > 256'(max_step_shadow)) return max_step_shadow;
      return quo[tctsp_pkg::WordW-1:0];
   endfunction

   function automatic step_type critical_step(tctsp_pkg::word_type f [12]);
      step_type r;
      logic degen;
      logic [tctsp_pkg::WordW-1:0] ta, tb, tc;
      degen = 1'b0;
      ta = vertex_time(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], degen);
      tb = vertex_time(f[2], f[3], f[4], f[5], f[0], f[1], f[8], f[9], degen);
      tc = vertex_time(f[4], f[5], f[0], f[1], f[2], f[3], f[10], f[11], degen);
      r.step_limit = ta;
      if (tb < r.step_limit) r.step_limit = tb;
      if (tc < r.step_limit) r.step_limit = tc;
      if (degen) r.step_limit = max_step_shadow;
      r.degenerate = degen;
      return r;
   endfunction

   function automatic logic [3:0] next_gap_class();
      return 4'($urandom_range(0, 9));
   endfunction

   // Driver: one beat per handshake, csr writes only with nothing in flight
   always @(posedge clock) begin
      logic next_start;
      logic next_csr_we;
      logic accepted;
      pending_type p;
      int cls;
      if (reset) begin
         start <= 1'b0;
         csr_write_en <= 1'b0;
         gap_left = 0;
         max_step_shadow = 32'h0001_0000;
         threshold_shadow = 32'd1;
      end else begin
         accepted = start && !busy;
         next_start = start && busy;
         next_csr_we = 1'b0;
         if (accepted) expected_steps.push_back(critical_step(req_f));
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               p = pending_beats[0];
               case (p.kind)
                  OpTriangle: begin
                     for (int i = 0; i < 12; i++) req_f[i] <= p.f[i];
                     next_start = 1'b1;
                     void'(pending_beats.pop_front());
                     cls = next_gap_class();
                     if (p.dense || cls < 6) gap_left = 0;
                     else if (cls < 9) gap_left = $urandom_range(1, 3);
                     else gap_left = $urandom_range(10, 60);
                  end
                  OpCsrWrite: begin
                     if (expected_steps.size() == 0) begin
                        next_csr_we = 1'b1;
                        csr_index <= p.idx;
                        csr_wdata <= p.wdata;
                        if (p.idx == tctsp_pkg::CsrMaxStep) max_step_shadow = p.wdata;
                        else threshold_shadow = p.wdata;
                        void'(pending_beats.pop_front());
                     end
                  end
                  default: begin
                     if (expected_steps.size() == 0) void'(pending_beats.pop_front());
                  end
               endcase
            end
         end
         csr_write_en <= next_csr_we;
         start <= next_start;
      end
   end

   // Monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      step_type e;
      if (!reset && rsp_valid) begin
         if (expected_steps.size() == 0) begin
            $display("%0t: unexpected result step_limit=%h degenerate=%b",
                     $time, rsp_step_limit, rsp_degenerate);
            failed = 1'b1;
         end else begin
            e = expected_steps.pop_front();
            if (rsp_step_limit !== e.step_limit) begin
               $display("%0t: step_limit expected %h actual %h",
                        $time, e.step_limit, rsp_step_limit);
               failed = 1'b1;
            end
            if (rsp_degenerate !== e.degenerate) begin
               $display("%0t: degenerate expected %b actual %b",
                        $time, e.degenerate, rsp_degenerate);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic tctsp_pkg::word_type rand_word(int shift);
      tctsp_pkg::word_type w;
      w = $urandom;
      return w >>> shift;
   endfunction

   task automatic add_triangle(tctsp_pkg::word_type f [12], logic dense);
      pending_type p;
      p.kind = OpTriangle;
      p.f = f;
      p.dense = dense;
      p.idx = tctsp_pkg::CsrMaxStep;
      p.wdata = '0;
      pending_beats.push_back(p);
   endtask

   task automatic add_csr(tctsp_pkg::csr_index_type idx, logic [tctsp_pkg::WordW-1:0] val);
      pending_type p;
      p.kind = OpCsrWrite;
      p.idx = idx;
      p.wdata = val;
      p.dense = 1'b0;
      foreach (p.f[i]) p.f[i] = '0;
      pending_beats.push_back(p);
   endtask

   task automatic add_drain();
      pending_type p;
      p.kind = OpDrain;
      p.idx = tctsp_pkg::CsrMaxStep;
      p.wdata = '0;
      p.dense = 1'b0;
      foreach (p.f[i]) p.f[i] = '0;
      pending_beats.push_back(p);
   endtask

   // Triangle of random shape and size; mostly well formed, some full-range noise
   task automatic add_random_triangle(logic dense);
      tctsp_pkg::word_type f [12];
      int cs, vs;
      if ($urandom_range(0, 9) == 0) begin
         foreach (f[i]) f[i] = $urandom;
      end else begin
         cs = $urandom_range(0, 24);
         vs = $urandom_range(0, 28);
         for (int i = 0; i < 6; i++) f[i] = rand_word(cs);
         for (int i = 6; i < 12; i++) f[i] = rand_word(vs);
         if ($urandom_range(0, 15) == 0) begin
            // collapse two vertices
            f[2] = f[0]; f[3] = f[1];
         end
      end
      add_triangle(f, dense);
   endtask

   task automatic add_directed();
      tctsp_pkg::word_type f [12];
      localparam tctsp_pkg::word_type One = 32'h0001_0000;
      localparam tctsp_pkg::word_type MaxW = 32'h7fff_ffff;
      localparam tctsp_pkg::word_type MinW = 32'h8000_0000;
      // all zero: degenerate
      foreach (f[i]) f[i] = '0;
      add_triangle(f, 1'b0);
      // right triangle, unit speed toward edges
      f = '{0, 0, One, 0, 0, One, One, One, -One, 0, 0, -One};
      add_triangle(f, 1'b0);
      // same, motion away from edges
      f = '{0, 0, One, 0, 0, One, -One, -One, One, 0, 0, One};
      add_triangle(f, 1'b0);
      // zero velocity
      f = '{0, 0, One, 0, 0, One, 0, 0, 0, 0, 0, 0};
      add_triangle(f, 1'b0);
      // collinear vertices: zero altitude
      f = '{0, 0, One, One, 2 * One, 2 * One, One, 0, 0, One, One, One};
      add_triangle(f, 1'b0);
      // zero edge
      f = '{One, One, One, One, 0, One, One, 0, 0, One, One, 0};
      add_triangle(f, 1'b0);
      // extreme coordinates and velocities
      f = '{MinW, MinW, MaxW, MinW, MinW, MaxW, MaxW, MaxW, MinW, 0, 0, MinW};
      add_triangle(f, 1'b0);
      f = '{MaxW, MaxW, MinW, MaxW, MaxW, MinW, MinW, MinW, MaxW, MinW, MinW, MaxW};
      add_triangle(f, 1'b0);
      // tiny triangle, very fast vertices: quotient truncates to zero
      f = '{0, 0, 1, 0, 0, 1, MaxW, MaxW, MinW, 0, 0, MinW};
      add_triangle(f, 1'b0);
      // huge triangle, slow vertices: saturates
      f = '{MinW, MinW, MaxW, MinW, MinW, MaxW, 1, 1, -1, 0, 0, -1};
      add_triangle(f, 1'b0);
      // all ones pattern and alternating bits
      foreach (f[i]) f[i] = (i % 2) ? 32'hffff_ffff : 32'h5555_5555;
      add_triangle(f, 1'b0);
      foreach (f[i]) f[i] = (i % 3) ? 32'haaaa_aaaa : 32'h1234_5678;
      add_triangle(f, 1'b0);
      for (int i = 0; i < 8; i++) add_random_triangle(1'b1);
   endtask

   // Stimulus: config phases, each followed by a drain
   initial begin
      logic [tctsp_pkg::WordW-1:0] ms [6];
      logic [tctsp_pkg::WordW-1:0] th [6];
      ms = '{32'h0001_0000, 32'hffff_ffff, 32'h0, 32'h0100_0000, 32'h0000_8000, 32'h0};
      th = '{32'd1, 32'h0, 32'hffff_ffff, 32'h0000_0100, 32'h0001_0000, 32'h0};
      ms[5] = $urandom;
      th[5] = $urandom_range(0, 32'h0002_0000);
      failed = 1'b0;
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      csr_write_en = 1'b0;
      csr_index = tctsp_pkg::CsrMaxStep;
      csr_wdata = '0;
      foreach (req_f[i]) req_f[i] = '0;
      add_directed();
      add_drain();
      for (int ph = 0; ph < 6; ph++) begin
         add_csr(tctsp_pkg::CsrMaxStep, ms[ph]);
         add_csr(tctsp_pkg::CsrSpeedThreshold, th[ph]);
         for (int n = 0; n < 72; n++) add_random_triangle(ph % 2 == 1 && n < 30);
         add_drain();
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_beats.size() == 0 && expected_steps.size() == 0);
      repeat (60) @(posedge clock);
      if (!failed && expected_steps.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
